// ----- sv/gsm_pkg.sv -----
package gsm_pkg;

    // audio sample width and limits
    localparam int S24_W = 24;
    localparam logic signed [S24_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [S24_W-1:0] S24_MIN = 24'sh800000;

    // gain smoothing constants
    localparam int GAIN_W = 32;                      // unsigned Q2.30, up to 2.0
    localparam int TGT_W = 16;                       // unsigned Q2.14
    localparam logic [TGT_W-1:0] TARGET_MAX = 16'd32768;
    localparam logic [TGT_W-1:0] TARGET_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h4000_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h8000_0000;
    localparam int ALPHA_SHIFT = 20;
    localparam int MULT_SHIFT = 14;

    // shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam logic signed [MUL_B_W-1:0] ALPHA_Q20 = 17'sd1049;

    // status of the iterative divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/gsm_ram.sv -----
module gsm_ram
    #(
        parameter int WIDTH = 24,
        parameter int DEPTH = 20
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/gsm_mul.sv -----
module gsm_mul
    import gsm_pkg::*;
    (
        input  logic                      clk,
        input  logic signed [MUL_A_W-1:0] a,
        input  logic signed [MUL_B_W-1:0] b,
        output logic signed [MUL_P_W-1:0] prod
    );

    logic signed [MUL_P_W-1:0] prod_reg;

    // one signed multiply per cycle, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- sv/gsm_div.sv -----
module gsm_div
    import gsm_pkg::*;
    #(
        parameter int WINDOW = 20,
        parameter int SUM_W = 29
    )
    (
        input  logic                    clk,
        input  logic                    rst_n,
        input  logic                    start,
        input  logic signed [SUM_W-1:0] sum_l,
        input  logic signed [SUM_W-1:0] sum_r,
        output div_stat_t               stat,
        output logic signed [S24_W-1:0] quo_l,
        output logic signed [S24_W-1:0] quo_r
    );

    // reciprocal scaled so that floor(mag * RECIP >> K_SHIFT) is exact for any SUM_W-bit mag
    localparam int K_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RCP_W   = SUM_W + 1;
    localparam int PRD_W   = SUM_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << K_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RECIP = RCP_FULL[RCP_W-1:0];
    localparam logic [1:0] LAST_STEP = 2'd2;

    logic signed [SUM_W-1:0] sum_in [2];
    logic [SUM_W-1:0]        mag [2];
    logic [SUM_W-1:0]        mul_in;

    logic [SUM_W-1:0]  mag_reg [2];
    logic              neg_reg [2];
    logic [PRD_W-1:0]  prod_reg;
    logic [S24_W-1:0]  quo_reg [2];
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    assign sum_in[0] = sum_l;
    assign sum_in[1] = sum_r;

    // magnitude per lane
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag[i] = sum_in[i][SUM_W-1] ? SUM_W'(-sum_in[i]) : SUM_W'(sum_in[i]);
        end
    end

    // left lane goes through the multiplier first, then the right
    assign mul_in = (cnt_reg == 2'd0) ? mag_reg[0] : mag_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 2; i++)
            begin
                mag_reg[i] <= mag[i];
                neg_reg[i] <= sum_in[i][SUM_W-1];
            end
        end
        else if (busy_reg)
        begin
            prod_reg <= PRD_W'(mul_in) * PRD_W'(RECIP);
            if (cnt_reg == 2'd1)
            begin
                quo_reg[0] <= prod_reg[K_SHIFT +: S24_W];
            end
            if (cnt_reg == LAST_STEP)
            begin
                quo_reg[1] <= prod_reg[K_SHIFT +: S24_W];
            end
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign quo_l = neg_reg[0] ? -$signed(quo_reg[0]) : $signed(quo_reg[0]);
    assign quo_r = neg_reg[1] ? -$signed(quo_reg[1]) : $signed(quo_reg[1]);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sv/stereo_gain_smoother_moving_average_core.sv -----
// stereo gain smoother with a per-channel moving average. each transfer on the input
// channel carries one left/right sample pair; the block first moves its smoothed gain one
// pole toward gain_target (step of 1049/2^20, about 0.001), multiplies both samples by
// the top 16 bits of that gain and saturates them to 24 bits, then runs each channel
// through its own WINDOW-sample moving average. the first WINDOW pairs pass through
// unchanged while the windows fill; after that each output is the running sum divided by
// WINDOW, truncated toward zero. one pair is processed at a time and every pair gives
// exactly one output transfer. during warm-up a pair passes the gain step and the two
// sample multiplies (one shared multiplier used three times in sequence); once the
// windows are full each pair also passes through the divide by WINDOW, a reciprocal
// multiply done for the left and then the right channel. a stalled output holds the
// finished pair in its last step until the output register is free; the next pair is
// taken as soon as the previous result sits in the output register. gain_target may only
// be written while no pair is in flight; cfg_ready is always high.
module stereo_gain_smoother_moving_average_core
    import gsm_pkg::*;
    #(
        parameter int WINDOW = 20
    )
    (
        input  logic                    clk,
        input  logic                    rst_n,
        // sample pair input
        input  logic                    in_valid,
        output logic                    in_stall,
        input  logic signed [S24_W-1:0] left_sample,
        input  logic signed [S24_W-1:0] right_sample,
        // result output
        output logic                    out_valid,
        input  logic                    out_stall,
        output logic signed [S24_W-1:0] left_out,
        output logic signed [S24_W-1:0] right_out,
        // gain target write
        input  logic                    cfg_valid,
        output logic                    cfg_ready,
        input  logic [TGT_W-1:0]        cfg_data
    );

    localparam int PW    = $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int SUM_W = S24_W + $clog2(WINDOW);
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GMUL = 4'd1;   // diff * alpha in the multiplier
    localparam logic [3:0] S_GUPD = 4'd2;   // apply gain step and clamp
    localparam logic [3:0] S_LMUL = 4'd3;   // left * gain
    localparam logic [3:0] S_LSAT = 4'd4;   // saturate left, update left window
    localparam logic [3:0] S_RMUL = 4'd5;   // right * gain
    localparam logic [3:0] S_RSAT = 4'd6;   // saturate right, update right window
    localparam logic [3:0] S_DIV  = 4'd7;   // wait for the divider
    localparam logic [3:0] S_OUT  = 4'd8;   // hand result to the output register

    logic [3:0] state_reg, state_next;

    // control and gain state
    logic [TGT_W-1:0]  gain_target_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PW-1:0]     pos_reg;
    logic [FW-1:0]     fill_reg;
    logic signed [SUM_W-1:0] sum_l_reg, sum_r_reg;
    logic              out_valid_reg;

    // payload
    logic signed [S24_W-1:0] left_in_reg, right_in_reg;
    logic signed [S24_W-1:0] y_l_reg, y_r_reg;
    logic signed [S24_W-1:0] left_out_reg, right_out_reg;

    // datapath signals
    logic [TGT_W-1:0]          tgt_sat;
    logic signed [MUL_A_W-1:0] diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [MUL_A_W:0]   g_sum;
    logic [GAIN_W-1:0]         g_next;
    logic signed [MUL_P_W-MULT_SHIFT-1:0] scaled;
    logic signed [S24_W-1:0]   y_sat;
    logic                      warm;
    logic                      out_free;
    logic                      in_xfer;
    logic signed [S24_W-1:0]   old_l, old_r;
    logic signed [S24_W-1:0]   old_sel;
    logic signed [SUM_W-1:0]   sum_l_next, sum_r_next;
    logic                      div_start;
    div_stat_t                 div_stat;
    logic signed [S24_W-1:0]   quo_l, quo_r;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE) | div_stat.busy;
    assign in_xfer   = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign warm      = (fill_reg < FILL_FULL);

    // target clamped to 2.0, then the gap to the current gain in Q2.30
    assign tgt_sat = (gain_target_reg > TARGET_MAX) ? TARGET_MAX : gain_target_reg;
    assign diff    = $signed({1'b0, tgt_sat, 16'h0000}) - $signed({1'b0, gain_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = diff;
        mul_b = ALPHA_Q20;
        case (state_reg)
            S_LMUL:
            begin
                mul_a = MUL_A_W'(left_in_reg);
                mul_b = $signed({1'b0, gain_reg[GAIN_W-1 -: 16]});
            end
            S_RMUL:
            begin
                mul_a = MUL_A_W'(right_in_reg);
                mul_b = $signed({1'b0, gain_reg[GAIN_W-1 -: 16]});
            end
            default:
            begin
                mul_a = diff;
                mul_b = ALPHA_Q20;
            end
        endcase
    end

    gsm_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // gain step with floor shift, clamped to 0..2.0
    always_comb
    begin
        g_sum = $signed({2'b00, gain_reg})
              + (MUL_A_W+1)'($signed(prod[MUL_P_W-1:ALPHA_SHIFT]));
        if (g_sum < 0)
        begin
            g_next = '0;
        end
        else if (g_sum > $signed({2'b00, GAIN_MAX}))
        begin
            g_next = GAIN_MAX;
        end
        else
        begin
            g_next = g_sum[GAIN_W-1:0];
        end
    end

    // sample times gain, floor shift by 14, saturate to 24 bits
    assign scaled = prod[MUL_P_W-1:MULT_SHIFT];
    always_comb
    begin
        if (scaled > (MUL_P_W-MULT_SHIFT)'(S24_MAX))
        begin
            y_sat = S24_MAX;
        end
        else if (scaled < (MUL_P_W-MULT_SHIFT)'(S24_MIN))
        begin
            y_sat = S24_MIN;
        end
        else
        begin
            y_sat = scaled[S24_W-1:0];
        end
    end

    // window stores, one per channel; read address is the slot about to be replaced
    gsm_ram #(.WIDTH(S24_W), .DEPTH(WINDOW)) u_ram_l
    (
        .clk   (clk),
        .we    (state_reg == S_LSAT),
        .waddr (pos_reg),
        .wdata (y_sat),
        .raddr (pos_reg),
        .rdata (old_l)
    );

    gsm_ram #(.WIDTH(S24_W), .DEPTH(WINDOW)) u_ram_r
    (
        .clk   (clk),
        .we    (state_reg == S_RSAT),
        .waddr (pos_reg),
        .wdata (y_sat),
        .raddr (pos_reg),
        .rdata (old_r)
    );

    // running sums: during warm-up nothing leaves the window
    assign old_sel    = (state_reg == S_LSAT) ? old_l : old_r;
    assign sum_l_next = sum_l_reg + SUM_W'(y_sat) - (warm ? '0 : SUM_W'(old_sel));
    assign sum_r_next = sum_r_reg + SUM_W'(y_sat) - (warm ? '0 : SUM_W'(old_sel));

    assign div_start = (state_reg == S_RSAT) & ~warm;

    gsm_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum_l (sum_l_reg),
        .sum_r (sum_r_next),
        .stat  (div_stat),
        .quo_l (quo_l),
        .quo_r (quo_r)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_GMUL;
            S_GMUL: state_next = S_GUPD;
            S_GUPD: state_next = S_LMUL;
            S_LMUL: state_next = S_LSAT;
            S_LSAT: state_next = S_RMUL;
            S_RMUL: state_next = S_RSAT;
            S_RSAT: state_next = warm ? S_OUT : S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gain_target_reg <= TARGET_RESET;
            gain_reg        <= GAIN_ONE;
            pos_reg         <= '0;
            fill_reg        <= '0;
            sum_l_reg       <= '0;
            sum_r_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                gain_target_reg <= cfg_data;
            end
            if (state_reg == S_GUPD)
            begin
                gain_reg <= g_next;
            end
            if (state_reg == S_LSAT)
            begin
                sum_l_reg <= sum_l_next;
            end
            if (state_reg == S_RSAT)
            begin
                sum_r_reg <= sum_r_next;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (warm)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            left_in_reg  <= left_sample;
            right_in_reg <= right_sample;
        end
        if (state_reg == S_LSAT)
        begin
            y_l_reg <= y_sat;
        end
        if (state_reg == S_RSAT)
        begin
            y_r_reg <= y_sat;
        end
        if (state_reg == S_OUT && out_free)
        begin
            left_out_reg  <= warm ? y_l_reg : quo_l;
            right_out_reg <= warm ? y_r_reg : quo_r;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ----- tb/sv/gain_average_checker.sv -----
module gain_average_checker
    import gsm_pkg::*;
    #(
        parameter int WINDOW = 20
    )
    (
        input  logic                    clk,
        input  logic                    rst_n,
        input  logic                    in_valid,
        input  logic                    in_stall,
        input  logic signed [S24_W-1:0] left_sample,
        input  logic signed [S24_W-1:0] right_sample,
        input  logic                    out_valid,
        input  logic                    out_stall,
        input  logic signed [S24_W-1:0] left_out,
        input  logic signed [S24_W-1:0] right_out,
        input  logic                    cfg_valid,
        input  logic                    cfg_ready,
        input  logic [TGT_W-1:0]        cfg_data,
        output int                      mismatches,
        output int                      pending
    );
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ALPHA       = 1049;     // ~0.001 in Q0.20
    localparam longint TARGET_CEIL = 32768;    // 2.0 in Q2.14
    localparam longint GAIN_UNITY  = 64'h4000_0000;
    localparam longint GAIN_CEIL   = 64'h8000_0000;
    localparam longint SAMPLE_HI   = 8388607;
    localparam longint SAMPLE_LO   = -8388608;
    localparam int     PRINT_MAX   = 40;

    typedef struct packed {
        logic signed [S24_W-1:0] left;
        logic signed [S24_W-1:0] right;
    } stereo_pair_t;

    logic [TGT_W-1:0]        target_gain;
    logic [31:0]             gain_q30;
    logic signed [S24_W-1:0] history [2][WINDOW];
    longint                  running_sum [2];
    int                      slot;
    int                      filled;
    stereo_pair_t            averaged_q [$];

    // one step of gain smoothing, gain multiply and per-channel averaging
    function automatic stereo_pair_t gain_and_average(input logic signed [S24_W-1:0] l_in,
                                                      input logic signed [S24_W-1:0] r_in);
        longint                  tgt;
        longint                  diff;
        longint                  g;
        longint                  gain16;
        longint                  x;
        longint                  y;
        longint                  avg;
        logic signed [S24_W-1:0] samples [2];
        logic signed [S24_W-1:0] res [2];
        bit                      warm;
        stereo_pair_t            pair;
        tgt = (longint'(target_gain) > TARGET_CEIL) ? TARGET_CEIL : longint'(target_gain);
        diff = (tgt <<< 16) - longint'(gain_q30);
        g = longint'(gain_q30) + ((diff * ALPHA) >>> 20);
        if (g < 0)
            g = 0;
        if (g > GAIN_CEIL)
            g = GAIN_CEIL;
        gain_q30 = g[31:0];
        gain16 = longint'(gain_q30[31:16]);
        warm = filled < WINDOW;
        samples[0] = l_in;
        samples[1] = r_in;
        for (int ch = 0; ch < 2; ch++)
        begin
            x = samples[ch];
            y = (x * gain16) >>> 14;
            if (y > SAMPLE_HI)
                y = SAMPLE_HI;
            if (y < SAMPLE_LO)
                y = SAMPLE_LO;
            if (warm)
            begin
                running_sum[ch] += y;
                avg = y;
            end
            else
            begin
                running_sum[ch] += y - longint'(history[ch][slot]);
                avg = running_sum[ch] / WINDOW;   // truncates toward zero
            end
            history[ch][slot] = y[S24_W-1:0];
            res[ch] = avg[S24_W-1:0];
        end
        if (warm)
            filled++;
        slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        pair.left = res[0];
        pair.right = res[1];
        return pair;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stereo_pair_t want;
        if (!rst_n)
        begin
            target_gain = 16'd16384;
            gain_q30 = GAIN_UNITY[31:0];
            running_sum[0] = 0;
            running_sum[1] = 0;
            slot = 0;
            filled = 0;
            for (int ch = 0; ch < 2; ch++)
                for (int i = 0; i < WINDOW; i++)
                    history[ch][i] = '0;
            averaged_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_gain = cfg_data;
            // result side first so a same-edge input never pairs with it
            if (out_valid && !out_stall)
            begin
                if (averaged_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_MAX)
                        $display("%0t: unexpected result left %0d right %0d",
                                 $realtime, left_out, right_out);
                end
                else
                begin
                    want = averaged_q.pop_front();
                    if (left_out !== want.left)
                    begin
                        mismatches++;
                        if (mismatches <= PRINT_MAX)
                            $display("%0t: left_out expected %0d actual %0d",
                                     $realtime, want.left, left_out);
                    end
                    if (right_out !== want.right)
                    begin
                        mismatches++;
                        if (mismatches <= PRINT_MAX)
                            $display("%0t: right_out expected %0d actual %0d",
                                     $realtime, want.right, right_out);
                    end
                end
            end
            if (in_valid && !in_stall)
                averaged_q.push_back(gain_and_average(left_sample, right_sample));
            pending = averaged_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top
    import gsm_pkg::*;
    ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 230;
    localparam int STALL_LIMIT = 2000;   // cycles with no transfer anywhere
    localparam int DRAIN_WAIT  = 50;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [S24_W-1:0] left_sample;
    logic signed [S24_W-1:0] right_sample;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [S24_W-1:0] left_out;
    logic signed [S24_W-1:0] right_out;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TGT_W-1:0]        cfg_data;

    int  mismatches;
    int  pending;
    int  in_idle_pct;    // chance per pair of a gap before it
    int  out_idle_pct;   // chance per cycle of a stall burst starting
    int  idle_cycles;
    // edge-sampled handshake results, read back at the falling edge
    logic in_taken;
    logic cfg_taken;

    stereo_gain_smoother_moving_average_core #(
        .WINDOW(WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .left_sample(left_sample),
        .right_sample(right_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_out(left_out),
        .right_out(right_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // predicts every pair and compares each output transfer
    gain_average_checker #(
        .WINDOW(WINDOW)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .left_sample(left_sample),
        .right_sample(right_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_out(left_out),
        .right_out(right_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            cfg_taken <= cfg_valid && cfg_ready;
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // output back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < out_idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // half full-range values, the other half extremes, near-extremes and small signed values
    function automatic logic signed [S24_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S24_MAX;
            1: return S24_MIN;
            2: return S24_W'($urandom_range(0, 64)) - S24_W'(32);
            3: return S24_MAX - S24_W'($urandom_range(0, 255));
            4: return S24_MIN + S24_W'($urandom_range(0, 255));
            default: return S24_W'($urandom());
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer,
    // with in_valid still high so the next pair can follow back to back
    task automatic send_pair(input logic signed [S24_W-1:0] l_val,
                             input logic signed [S24_W-1:0] r_val);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        left_sample <= l_val;
        right_sample <= r_val;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    // gain target may only change with no pair in flight
    task automatic write_target(input logic [TGT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [TGT_W-1:0] tgt;
        in_valid = 1'b0;
        left_sample = '0;
        right_sample = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes at unity gain, through warm-up and into averaging
        send_pair(S24_MAX, S24_MIN);
        send_pair(S24_MIN, S24_MAX);
        send_pair('0, '0);
        send_pair(-24'sd1, 24'sd1);
        send_pair(24'sd1, -24'sd1);
        send_pair(24'sh555555, 24'shAAAAAA);
        for (int i = 0; i < 18; i++)
            send_pair((i % 2) ? S24_MIN : S24_MAX, (i % 3 == 0) ? -24'sd1 : S24_MIN);

        // random phases, each with its own gain target and idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: tgt = TARGET_MAX;                       // climb toward 2.0, saturation
                1: tgt = 16'hFFFF;                         // above 2.0, clamps
                2: tgt = 16'h0000;                         // fall toward zero
                3: tgt = TGT_W'($urandom_range(0, 65535));
                4: tgt = TARGET_RESET;
                default: tgt = TGT_W'($urandom_range(0, 65535));
            endcase
            write_target(tgt);
            if (p == PHASES - 1)
            begin
                // closing stretch runs at full rate
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
            repeat (PHASE_ITEMS) send_pair(pick_sample(), pick_sample());
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
